/* rtl/djc_pkg.sv */
// ----------------------------------------------------------------------------
// djc_pkg - shared types and constants for the depth to jet colour block
// Holds the fixed-point constants of the jet scale, the configuration
// register indexes and the per-channel level function.
// ----------------------------------------------------------------------------
`default_nettype none

package djc_pkg;

  // fraction bits of the gray scale
  localparam int FRAC_BITS = 24;

  // configuration port
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 25;
  localparam int MIN_DEPTH_BITS = 16;
  localparam int INV_RANGE_BITS = 25;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_DEPTH = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INV_RANGE = 1'd1;

  localparam logic [MIN_DEPTH_BITS-1:0] MIN_DEPTH_RESET = 16'd0;
  localparam logic [INV_RANGE_BITS-1:0] INV_RANGE_RESET = 25'd256;

  // saturated gray in [-2, 2], and v = gray +/- 0.5
  localparam int GRAY_BITS = 27;
  localparam int V_BITS    = 28;
  localparam int MAG_BITS  = 27;
  localparam int BASE_BITS = 33;

  localparam logic signed [GRAY_BITS-1:0] GRAY_LIMIT = 27'sd33554432;  // 2.0
  localparam logic signed [V_BITS-1:0]    HALF_Q     = 28'sd8388608;   // 0.5

  // |v| at or below 0.25 gives full level, at or above 0.75 gives zero
  localparam logic [MAG_BITS-1:0]  MAG_FULL  = 27'd4194304;
  localparam logic [MAG_BITS-1:0]  MAG_ZERO  = 27'd12582912;
  localparam logic [BASE_BITS-1:0] BASE_ONE  = 33'd16777216;   // 1.0
  localparam logic [BASE_BITS-1:0] BASE_PEAK = 33'd25165824;   // 1.5

  localparam logic [7:0] LEVEL_WHITE = 8'd255;

  // status carried alongside each word in the pipeline
  typedef struct packed {
    logic valid;
    logic blank;
  } djc_tag_t;

  // floor(255 * clamp(1.5 - 2|v|, 0, 1))
  function automatic logic [7:0] channel_level(input logic signed [V_BITS-1:0] v);
    logic [MAG_BITS-1:0]  mag;
    logic [BASE_BITS-1:0] base;
    logic [BASE_BITS-1:0] scaled;
    mag = v[V_BITS-1] ? MAG_BITS'(-v) : MAG_BITS'(v);
    if (mag >= MAG_ZERO) begin
      base = '0;
    end else if (mag <= MAG_FULL) begin
      base = BASE_ONE;
    end else begin
      base = BASE_PEAK - {5'd0, mag, 1'b0};
    end
    // 255*b as (b << 8) - b
    scaled = {base[BASE_BITS-9:0], 8'd0} - base;
    return scaled[FRAC_BITS+7:FRAC_BITS];
  endfunction

endpackage

`default_nettype wire

/* rtl/djc_mult.sv */
// ----------------------------------------------------------------------------
// djc_mult - offset and scale stage
// Subtracts the minimum depth and multiplies by the inverse range,
// registering the signed product.
// ----------------------------------------------------------------------------
`default_nettype none

module djc_mult #(
  parameter int DEPTH_BITS = 16
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire  djc_pkg::djc_tag_t           tag_in,
  input  wire  [DEPTH_BITS-1:0]             depth,
  input  wire  [DEPTH_BITS-1:0]             min_depth,
  input  wire  [djc_pkg::INV_RANGE_BITS-1:0] inv_range,
  output djc_pkg::djc_tag_t                 tag_out,
  output logic signed [DEPTH_BITS+26:0]     prod
);

  localparam int PROD_BITS = DEPTH_BITS + 27;

  logic signed [DEPTH_BITS:0]                 diff;
  logic signed [djc_pkg::INV_RANGE_BITS:0]    inv_s;
  logic signed [PROD_BITS-1:0]                prod_nxt;
  logic signed [PROD_BITS-1:0]                prod_r;
  djc_pkg::djc_tag_t                          tag_r;

  // signed offset from the minimum, times the unsigned scale
  assign diff     = $signed({1'b0, depth}) - $signed({1'b0, min_depth});
  assign inv_s    = $signed({1'b0, inv_range});
  assign prod_nxt = diff * inv_s;

  // product register
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // tag register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_in;
    end
  end

  assign prod    = prod_r;
  assign tag_out = tag_r;

endmodule

`default_nettype wire

/* rtl/djc_shade.sv */
// ----------------------------------------------------------------------------
// djc_shade - gray saturation and colour channel stages
// Turns the scaled product into a saturated gray level, then into the
// three jet colour channels; a blank word gives white.
// ----------------------------------------------------------------------------
`default_nettype none

module djc_shade #(
  parameter int DEPTH_BITS = 16
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire djc_pkg::djc_tag_t        tag_in,
  input  wire signed [DEPTH_BITS+26:0]  prod,
  output logic                          strobe,
  output logic [7:0]                    red,
  output logic [7:0]                    green,
  output logic [7:0]                    blue
);

  localparam int PROD_BITS = DEPTH_BITS + 27;
  localparam int WIDE_BITS = PROD_BITS + 2;
  localparam logic signed [WIDE_BITS-1:0] ONE_W  = WIDE_BITS'(1) <<< djc_pkg::FRAC_BITS;
  localparam logic signed [WIDE_BITS-1:0] LIM_W  = WIDE_BITS'(2) <<< djc_pkg::FRAC_BITS;

  logic signed [WIDE_BITS-1:0]              gray_wide;
  logic signed [djc_pkg::GRAY_BITS-1:0]     gray_nxt;
  logic signed [djc_pkg::GRAY_BITS-1:0]     gray_r;
  djc_pkg::djc_tag_t                        tag_r;

  logic signed [djc_pkg::V_BITS-1:0]        gray_v;
  logic [7:0]                               red_nxt, green_nxt, blue_nxt;
  logic [7:0]                               red_r, green_r, blue_r;
  logic                                     strobe_r;

  // gray = 2*prod - 1, saturated to [-2, 2]
  assign gray_wide = (WIDE_BITS'(prod) <<< 1) - ONE_W;

  always_comb begin
    if (gray_wide > LIM_W) begin
      gray_nxt = djc_pkg::GRAY_LIMIT;
    end else if (gray_wide < -LIM_W) begin
      gray_nxt = -djc_pkg::GRAY_LIMIT;
    end else begin
      gray_nxt = gray_wide[djc_pkg::GRAY_BITS-1:0];
    end
  end

  // gray register
  always_ff @(posedge clk) begin
    gray_r <= gray_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_in;
    end
  end

  // channel levels, white for a missing sample
  assign gray_v = djc_pkg::V_BITS'(gray_r);

  always_comb begin
    if (tag_r.blank) begin
      red_nxt   = djc_pkg::LEVEL_WHITE;
      green_nxt = djc_pkg::LEVEL_WHITE;
      blue_nxt  = djc_pkg::LEVEL_WHITE;
    end else begin
      red_nxt   = djc_pkg::channel_level(gray_v - djc_pkg::HALF_Q);
      green_nxt = djc_pkg::channel_level(gray_v);
      blue_nxt  = djc_pkg::channel_level(gray_v + djc_pkg::HALF_Q);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= tag_r.valid;
    end
  end

  assign strobe = strobe_r;
  assign red    = red_r;
  assign green  = green_r;
  assign blue   = blue_r;

endmodule

`default_nettype wire

/* rtl/depth_to_jet_color.sv */
// ----------------------------------------------------------------------------
// depth_to_jet_color - jet colour map for raw depth samples
// Maps each depth sample to an RGB triple on the jet scale.
//
// Usage:
//   Input words are taken on in_depth at each clock edge with start high
//   and busy low. busy is high only during reset and the cycle after it;
//   from then on one word can be taken every cycle.
//   Each result appears on out_red, out_green and out_blue for one cycle
//   with out_strobe high, after its word has passed the input, product,
//   gray and result registers; results come out in order.
//   The pipeline is input register, multiply, gray saturation, colour
//   channel register; the 17 x 26 bit multiply stage sets the clock rate.
//   The receiver cannot stall, so nothing is held back.
//   A depth of zero gives white. min_depth and inv_depth_range are written
//   through cfg_valid/cfg_ready with cfg_index and cfg_data; write them
//   only while no word is in flight. Reset sets min_depth to 0 and
//   inv_depth_range to 256 and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_to_jet_color #(
  parameter int DEPTH_BITS = 16
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // input words
  input  wire                                start,
  output logic                               busy,
  input  wire  [15:0]                        in_depth,
  // results
  output logic                               out_strobe,
  output logic [7:0]                         out_red,
  output logic [7:0]                         out_green,
  output logic [7:0]                         out_blue,
  // configuration writes
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [djc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire  [djc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int PROD_BITS = DEPTH_BITS + 27;

  logic                                  busy_r;
  logic                                  accept;
  logic [DEPTH_BITS-1:0]                 depth_r;
  djc_pkg::djc_tag_t                     tag_in_r;
  logic [djc_pkg::MIN_DEPTH_BITS-1:0]    min_depth_r;
  logic [djc_pkg::INV_RANGE_BITS-1:0]    inv_range_r;
  djc_pkg::djc_tag_t                     tag_mult;
  logic signed [PROD_BITS-1:0]           prod;

  assign accept = start && !busy_r;

  // busy only while leaving reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = !busy_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_depth_r <= djc_pkg::MIN_DEPTH_RESET;
      inv_range_r <= djc_pkg::INV_RANGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        djc_pkg::REG_MIN_DEPTH: min_depth_r <= cfg_data[djc_pkg::MIN_DEPTH_BITS-1:0];
        djc_pkg::REG_INV_RANGE: inv_range_r <= cfg_data[djc_pkg::INV_RANGE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    depth_r <= in_depth[DEPTH_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_in_r <= '0;
    end else begin
      tag_in_r.valid <= accept;
      tag_in_r.blank <= (in_depth[DEPTH_BITS-1:0] == '0);
    end
  end

  djc_mult #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_in    (tag_in_r),
    .depth     (depth_r),
    .min_depth (min_depth_r[DEPTH_BITS-1:0]),
    .inv_range (inv_range_r),
    .tag_out   (tag_mult),
    .prod      (prod)
  );

  djc_shade #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_shade (
    .clk    (clk),
    .rst_n  (rst_n),
    .tag_in (tag_mult),
    .prod   (prod),
    .strobe (out_strobe),
    .red    (out_red),
    .green  (out_green),
    .blue   (out_blue)
  );

  // every result comes from a word taken earlier at the input
  a_strobe_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, 4))
    else $error("result without a matching input word");

  // a missing sample shows white
  a_blank_is_white: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(accept && (in_depth[DEPTH_BITS-1:0] == '0), 4))
      |-> (out_red == djc_pkg::LEVEL_WHITE && out_green == djc_pkg::LEVEL_WHITE &&
           out_blue == djc_pkg::LEVEL_WHITE))
    else $error("missing sample not shown white");

  // zero range maps every sample to gray -1: dark blue
  a_zero_range_blue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && inv_range_r == '0 &&
     $past(accept && (in_depth[DEPTH_BITS-1:0] != '0), 4))
      |-> (out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd127))
    else $error("zero range does not give gray minus one");

  // no word enters while leaving reset
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |=> !tag_in_r.valid)
    else $error("word taken while busy");

endmodule

`default_nettype wire
